FILE: rtl/text_case_normalizer_macros.svh
// assertion helpers shared by text_case_normalizer and tcn_out_queue
`ifndef TEXT_CASE_NORMALIZER_MACROS_SVH
`define TEXT_CASE_NORMALIZER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TCN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TCN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tcn_pkg.sv
`timescale 1ns / 1ps

package tcn_pkg;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_QUEST = 8'h3F;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_LOW_I = 8'h69;
  localparam logic [7:0] CHAR_UP_I  = 8'h49;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // lone-i scan phases
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_BLANK   = 2'd1;
  localparam logic [1:0] PHASE_BLANK_I = 2'd2;

  // output queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_CW    = 3;

  typedef struct packed {
    logic       sentence_start;
    logic [1:0] scan_phase;
  } tcn_ctx_t;

  typedef struct packed {
    logic       eot;
    logic [7:0] data;
  } tcn_word_t;

  localparam tcn_ctx_t CTX_RESET = '{sentence_start: 1'b1, scan_phase: PHASE_IDLE};

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

FILE: rtl/text_case_normalizer.sv
`timescale 1ns / 1ps
`include "text_case_normalizer_macros.svh"

// text case normalizer: rewrites an all-uppercase byte stream in sentence case
// input channel in_*: one text byte per word, in_tlast marks the message end
// output channel out_*: corrected bytes, out_tlast on the final byte of a message
// each byte is held back by one word, since the lone-i rule needs the next byte;
// the held byte leaves the block when the next input word is accepted
// a word with in_tlast emits the held byte and then itself, and clears all state
// latency: a word enters the output queue one accepted word later, or in the same
// cycle for the last word, and can show on out_* from the cycle after that
// throughput: one input word per cycle while in_tready is high; a message's first word
// pushes nothing, its last pushes two, so it gives as many output words as input words
// in_tready is set by room in a four-word output queue: it stays high while the
// receiver keeps up, and drops when the receiver stalls and two words no longer fit
// reset: sentence start set, scan phase idle, no byte held, queue empty
module text_case_normalizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,   // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // end_of_text
);
  import tcn_pkg::*;

  // per-message context and the byte held back for the lone-i rule
  tcn_ctx_t   ctx_r, ctx_nxt, ctx_calc;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;

  logic [7:0] conv_byte;
  logic       patch_held;
  logic       in_fire;
  logic       room_two;
  logic [1:0] push_n;
  tcn_word_t  push_a, push_b, cur_word, held_word, head_word;

  tcn_case_pass u_case_pass (
    .byte_in    (in_tdata),
    .ctx_in     (ctx_r),
    .byte_out   (conv_byte),
    .ctx_out    (ctx_calc),
    .patch_held (patch_held)
  );

  assign in_tready = room_two;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    // held byte turns into a capital I when the lone-i pattern completes
    held_word.data = patch_held ? CHAR_UP_I : held_byte_r;
    held_word.eot  = 1'b0;
    cur_word.data  = conv_byte;
    cur_word.eot   = 1'b1;

    push_n = 2'd0;
    push_a = held_valid_r ? held_word : cur_word;
    push_b = cur_word;
    if (in_fire) begin
      push_n = {1'b0, held_valid_r} + {1'b0, in_tlast};
    end

    ctx_nxt        = ctx_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    if (in_fire) begin
      if (in_tlast) begin
        // message done: back to the reset context
        ctx_nxt        = CTX_RESET;
        held_valid_nxt = 1'b0;
      end else begin
        ctx_nxt        = ctx_calc;
        held_byte_nxt  = conv_byte;
        held_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r        <= CTX_RESET;
      held_valid_r <= 1'b0;
    end else begin
      ctx_r        <= ctx_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  tcn_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push_a     (push_a),
    .push_b     (push_b),
    .room_two   (room_two),
    .head_valid (out_tvalid),
    .head_word  (head_word),
    .head_ready (out_tready)
  );

  assign out_tdata = head_word.data;
  assign out_tlast = head_word.eot;

  `TCN_ASSERT_NEXT(a_last_clears, clk, rst_n, in_fire && in_tlast,
    !held_valid_r && ctx_r == CTX_RESET, "state not cleared after last word")
  `TCN_ASSERT_NEXT(a_fire_holds, clk, rst_n, in_fire && !in_tlast,
    held_valid_r, "byte not held after accepted word")
  `TCN_ASSERT_NOW(a_phase_legal, clk, rst_n, 1'b1,
    ctx_r.scan_phase != 2'd3, "unused scan phase reached")

endmodule

FILE: rtl/tcn_case_pass.sv
`timescale 1ns / 1ps

// case conversion and lone-i detection for one byte
module tcn_case_pass (
  input  logic [7:0]       byte_in,
  input  tcn_pkg::tcn_ctx_t ctx_in,
  output logic [7:0]       byte_out,
  output tcn_pkg::tcn_ctx_t ctx_out,
  output logic             patch_held
);
  import tcn_pkg::*;

  logic letter;
  logic punct;

  always_comb begin
    letter = is_letter(byte_in);
    punct  = (byte_in == CHAR_DOT) || (byte_in == CHAR_QUEST) || (byte_in == CHAR_BANG);

    byte_out               = byte_in;
    ctx_out.sentence_start = ctx_in.sentence_start;
    if (punct) begin
      ctx_out.sentence_start = 1'b1;
    end else if (letter) begin
      byte_out = ctx_in.sentence_start ? (byte_in & ~CASE_BIT) : (byte_in | CASE_BIT);
      ctx_out.sentence_start = 1'b0;
    end

    patch_held = 1'b0;
    unique case (ctx_in.scan_phase)
      PHASE_BLANK: begin
        ctx_out.scan_phase = (byte_out == CHAR_LOW_I) ? PHASE_BLANK_I : PHASE_IDLE;
      end
      PHASE_BLANK_I: begin
        ctx_out.scan_phase = is_blank(byte_out) ? PHASE_BLANK : PHASE_IDLE;
        patch_held         = !letter;
      end
      default: begin
        ctx_out.scan_phase = is_blank(byte_out) ? PHASE_BLANK : PHASE_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/tcn_out_queue.sv
`timescale 1ns / 1ps
`include "text_case_normalizer_macros.svh"

// small output queue: up to two words in per cycle, one word out
module tcn_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  tcn_pkg::tcn_word_t push_a,
  input  tcn_pkg::tcn_word_t push_b,
  output logic              room_two,
  output logic              head_valid,
  output tcn_pkg::tcn_word_t head_word,
  input  logic              head_ready
);
  import tcn_pkg::*;

  tcn_word_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_r, wr_ptr_nxt, wr_ptr_inc;
  logic [QUEUE_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]     count_r, count_nxt;
  logic                    pop;

  assign head_valid = (count_r != '0);
  assign head_word  = mem_r[rd_ptr_r];
  assign room_two   = (count_r <= QUEUE_CW'(QUEUE_DEPTH - 2));
  assign pop        = head_valid && head_ready;
  assign wr_ptr_inc = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QUEUE_AW'(push_n);
    rd_ptr_nxt = rd_ptr_r + QUEUE_AW'(pop);
    count_nxt  = count_r + QUEUE_CW'(push_n) - QUEUE_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_ptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_ptr_inc] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `TCN_ASSERT_NOW(a_no_overflow, clk, rst_n, push_n != 2'd0, room_two, "push into full queue")
  `TCN_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= QUEUE_CW'(QUEUE_DEPTH), "count above depth")
  `TCN_ASSERT_NOW(a_ptr_track, clk, rst_n, 1'b1,
    QUEUE_AW'(wr_ptr_r - rd_ptr_r) == QUEUE_AW'(count_r), "pointers disagree with count")

endmodule

FILE: tb/sv/text_case_normalizer_test.sv
`timescale 1ns / 1ps

module text_case_normalizer_test;
  import tcn_pkg::*;

  // run bounds
  localparam int TARGET_WORDS = 1775;   // directed words plus the random part
  localparam int CYCLE_LIMIT  = 100000;
  localparam int TAIL_CYCLES  = 20;     // quiet cycles after the last result
  localparam int IDLE_PCT     = 8;
  localparam int QUIET_LO     = 700;    // no random idling on either side in this window
  localparam int QUIET_HI     = 1000;
  localparam int STALL_AT     = 200;    // receiver holds off after this many results
  localparam int STALL_LEN    = 150;

  // one text byte waiting to be offered
  typedef struct {
    logic [7:0] ch;
    logic       eom;
    bit         drain_first;  // wait until every result is in before offering
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] text_byte
  logic       in_tlast = 1'b0;    // last_char
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tlast;          // end_of_text

  text_item_t text_q[$];          // bytes not yet offered
  tcn_word_t  expected_words[$];  // corrected bytes still to arrive

  // own copy of the normalizer state, at its reset values
  logic       cap_next = 1'b1;
  logic [1:0] lone_i_phase = PHASE_IDLE;
  logic [7:0] held_char = 8'h00;
  logic       held_ok = 1'b0;

  int words_sent = 0;
  int msgs_sent = 0;
  int words_seen = 0;
  int drain_pauses = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;
  int error_count = 0;
  int cycle_count = 0;

  text_case_normalizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // ascii letters only, both cases
  function automatic bit alpha_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // tab, line feed, vertical tab, form feed, carriage return and space
  function automatic bit blank_char(input logic [7:0] c);
    return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // runs one accepted input word through the sentence-case and lone-i rules,
  // queueing the corrected bytes it releases
  task automatic normalize_word(input logic [7:0] raw, input logic last);
    logic [7:0] c;
    logic [1:0] nxt;
    c = raw;
    // sentence case: first letter after an end mark goes up, the rest down
    if (c == CHAR_DOT || c == CHAR_QUEST || c == CHAR_BANG) begin
      cap_next = 1'b1;
    end else if (alpha_char(c)) begin
      c = cap_next ? (c & ~CASE_BIT) : (c | CASE_BIT);
      cap_next = 1'b0;
    end
    // lone i: blank, then 'i', then a non-letter rewrites the held 'i'
    if (lone_i_phase == PHASE_BLANK) begin
      nxt = (c == CHAR_LOW_I) ? PHASE_BLANK_I : PHASE_IDLE;
    end else begin
      nxt = blank_char(c) ? PHASE_BLANK : PHASE_IDLE;
      if (lone_i_phase == PHASE_BLANK_I && !alpha_char(c)) held_char = CHAR_UP_I;
    end
    lone_i_phase = nxt;
    if (held_ok) expected_words.push_back(tcn_word_t'{eot: 1'b0, data: held_char});
    if (last) begin
      // the final byte goes out at once and the message state starts over
      expected_words.push_back(tcn_word_t'{eot: 1'b1, data: c});
      cap_next = 1'b1;
      lone_i_phase = PHASE_IDLE;
      held_char = 8'h00;
      held_ok = 1'b0;
    end else begin
      held_char = c;
      held_ok = 1'b1;
    end
  endtask

  task automatic push_text(input string s, input bit drain);
    text_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i];
      it.eom = (i == s.len() - 1);
      it.drain_first = drain && (i == 0);
      text_q.push_back(it);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eom);
    text_item_t it;
    it.ch = b;
    it.eom = eom;
    it.drain_first = 1'b0;
    text_q.push_back(it);
  endtask

  // mostly shouting text with blanks, lone i's and end marks, some odd bytes
  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'h41 + 8'($urandom_range(25));
    if (r < 60) return CHAR_SPACE;
    if (r < 70) return "I";
    if (r < 73) return CHAR_DOT;
    if (r < 76) return CHAR_QUEST;
    if (r < 79) return CHAR_BANG;
    if (r < 84) return 8'($urandom_range(13, 9));
    if (r < 90) return 8'h61 + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  task automatic push_random_message(input bit drain);
    int len;
    bit noise;
    text_item_t it;
    len = $urandom_range(24, 1);
    noise = ($urandom_range(9) == 0);  // broken message of raw bytes
    for (int i = 0; i < len; i++) begin
      it.ch = noise ? 8'($urandom_range(255)) : text_char();
      it.eom = (i == len - 1);
      it.drain_first = drain && (i == 0);
      text_q.push_back(it);
    end
  endtask

  // sender: offers the queued bytes, predicts each word as it is taken
  always @(posedge clk) begin : drive_proc
    text_item_t it;
    bit offering;
    bit go;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      offering = in_tvalid;
      if (in_tvalid && in_tready) begin
        normalize_word(in_tdata, in_tlast);
        words_sent++;
        if (in_tlast) msgs_sent++;
        offering = 1'b0;
      end
      if (!offering) begin
        go = text_q.size() != 0;
        if (go && !(words_sent >= QUIET_LO && words_sent < QUIET_HI))
          go = ($urandom_range(99) >= IDLE_PCT);
        // drain pause: hold the next message until the output side is empty
        if (go && text_q[0].drain_first && expected_words.size() != 0) go = 1'b0;
        if (go) begin
          it = text_q.pop_front();
          if (it.drain_first) drain_pauses++;
          in_tdata <= it.ch;
          in_tlast <= it.eom;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks every word against the oldest expectation
  always @(posedge clk) begin : check_proc
    tcn_word_t want;
    logic ready_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          error_count++;
          $display("%0t: unexpected word, expected none, actual data %02h last %0b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = expected_words.pop_front();
          if (out_tdata !== want.data) begin
            error_count++;
            $display("%0t: out_tdata mismatch, expected %02h actual %02h",
                     $time, want.data, out_tdata);
          end
          if (out_tlast !== want.eot) begin
            error_count++;
            $display("%0t: out_tlast mismatch, expected %0b actual %0b",
                     $time, want.eot, out_tlast);
          end
        end
        words_seen++;
      end
      // one long hold-off so the output queue fills and in_tready drops
      if (stall_left != 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!stall_done && words_seen >= STALL_AT) begin
        stall_left = STALL_LEN - 1;
        stall_done = 1'b1;
        ready_next = 1'b0;
      end else if (words_seen >= QUIET_LO && words_seen < QUIET_HI) begin
        ready_next = 1'b1;
      end else begin
        ready_next = ($urandom_range(99) >= IDLE_PCT);
      end
      out_tready <= ready_next;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words still expected", $time, expected_words.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int msg_no;
    // lone capital i as a whole message
    push_text("I", 1'b0);
    // end marks, tab as blank, double blank, trailing lone i left alone
    push_text("GO. I AM\tI! X  I", 1'b0);
    // byte extremes, lowercase input, carriage return and line feed around an i
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(CHAR_QUEST, 1'b0);
    push_byte("a", 1'b0);
    push_byte("z", 1'b0);
    push_byte(8'h0D, 1'b0);
    push_byte("I", 1'b0);
    push_byte(8'h0A, 1'b1);
    msg_no = 0;
    while (text_q.size() < TARGET_WORDS) begin
      push_random_message(msg_no == 40 || $urandom_range(99) < 3);
      msg_no++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d words in %0d messages, checked %0d corrected words",
             words_sent, msgs_sent, words_seen);
    $display("one long receiver stall, %0d drain pauses, random idling on both sides",
             drain_pauses);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
